FILE: src/pid_pkg.sv
// ----------------------------------------------------------------------------
// pid_pkg
// Shared types and constants for the positional PID step block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pid_pkg;

  localparam int GainWidth       = 16;
  localparam int CfgIdxWidth     = 3;
  localparam int QueueDepth      = 4;

  localparam int DefSampleWidth  = 16;
  localparam int DefGainFracBits = 8;
  localparam int DefSumWidth     = 32;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_GAIN_PROP  = 3'd0,
    REG_GAIN_INTEG = 3'd1,
    REG_GAIN_DERIV = 3'd2,
    REG_LIMIT_HIGH = 3'd3,
    REG_LIMIT_LOW  = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

FILE: src/pid_front.sv
// ----------------------------------------------------------------------------
// pid_front
// Accepts control ticks, forms the error, its first difference and the
// saturating integral, and pushes them into the work queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pid_front #(
  parameter int SAMPLE_WIDTH = pid_pkg::DefSampleWidth,
  parameter int SUM_WIDTH    = pid_pkg::DefSumWidth
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [SAMPLE_WIDTH-1:0]    setpoint_i,
  input  logic signed [SAMPLE_WIDTH-1:0]    measured_i,
  input  logic signed [pid_pkg::GainWidth-1:0] gain_integ_i,
  input  pid_pkg::q_stat_t                  q_stat_i,
  output logic                              push_o,
  output logic signed [SAMPLE_WIDTH:0]      err_o,
  output logic signed [SAMPLE_WIDTH+1:0]    diff_o,
  output logic signed [SUM_WIDTH-1:0]       integ_o
);
  import pid_pkg::*;

  localparam int EW = SAMPLE_WIDTH + 1;
  localparam int DW = SAMPLE_WIDTH + 2;
  localparam int SX = ((SUM_WIDTH > EW) ? SUM_WIDTH : EW) + 1;

  logic signed [EW-1:0]        last_error_q, last_error_d;
  logic signed [SUM_WIDTH-1:0] error_sum_q, error_sum_d;
  logic signed [EW-1:0]        err;
  logic signed [DW-1:0]        diff;
  logic signed [SX-1:0]        sum_ext;
  logic                        ovf_pos, ovf_neg;

  assign in_stall_o = q_stat_i.full;
  assign push_o     = in_valid_i && !q_stat_i.full;

  always_comb begin
    err     = EW'(setpoint_i) - EW'(measured_i);
    diff    = DW'(err) - DW'(last_error_q);
    sum_ext = SX'(error_sum_q) + SX'(err);
    ovf_neg = sum_ext[SX-1] && !(&sum_ext[SX-2:SUM_WIDTH-1]);
    ovf_pos = !sum_ext[SX-1] && (|sum_ext[SX-2:SUM_WIDTH-1]);
    if (gain_integ_i == '0) begin
      error_sum_d = '0;
    end else if (ovf_neg) begin
      error_sum_d = {1'b1, {(SUM_WIDTH-1){1'b0}}};
    end else if (ovf_pos) begin
      error_sum_d = {1'b0, {(SUM_WIDTH-1){1'b1}}};
    end else begin
      error_sum_d = sum_ext[SUM_WIDTH-1:0];
    end
    last_error_d = err;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_error_q <= '0;
      error_sum_q  <= '0;
    end else if (push_o) begin
      last_error_q <= last_error_d;
      error_sum_q  <= error_sum_d;
    end
  end

  assign err_o   = err;
  assign diff_o  = diff;
  assign integ_o = error_sum_d;

endmodule

FILE: src/pid_queue.sv
// ----------------------------------------------------------------------------
// pid_queue
// Small first-in first-out queue between the front and back parts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pid_queue #(
  parameter int Width = 8,
  parameter int Depth = pid_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output pid_pkg::q_stat_t q_stat_o
);
  import pid_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign do_push = push_i && (count_q != CntW'(Depth));
  assign do_pop  = pop_i && (count_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  assign rdata_o        = mem_q[rd_ptr_q];
  assign q_stat_o.full  = (count_q == CntW'(Depth));
  assign q_stat_o.empty = (count_q == '0);

endmodule

FILE: src/pid_back.sv
// ----------------------------------------------------------------------------
// pid_back
// Three-stage datapath: gain products, wide sum, then scale and clamp into
// the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pid_back #(
  parameter int SAMPLE_WIDTH   = pid_pkg::DefSampleWidth,
  parameter int GAIN_FRAC_BITS = pid_pkg::DefGainFracBits,
  parameter int SUM_WIDTH      = pid_pkg::DefSumWidth
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  pid_pkg::q_stat_t                     q_stat_i,
  output logic                                 pop_o,
  input  logic signed [SAMPLE_WIDTH:0]         err_i,
  input  logic signed [SAMPLE_WIDTH+1:0]       diff_i,
  input  logic signed [SUM_WIDTH-1:0]          integ_i,
  input  logic signed [pid_pkg::GainWidth-1:0] gain_prop_i,
  input  logic signed [pid_pkg::GainWidth-1:0] gain_integ_i,
  input  logic signed [pid_pkg::GainWidth-1:0] gain_deriv_i,
  input  logic signed [SAMPLE_WIDTH-1:0]       limit_high_i,
  input  logic signed [SAMPLE_WIDTH-1:0]       limit_low_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [SAMPLE_WIDTH-1:0]       drive_o
);
  import pid_pkg::*;

  localparam int EW = SAMPLE_WIDTH + 1;
  localparam int DW = SAMPLE_WIDTH + 2;
  localparam int PW = GainWidth + EW;
  localparam int IW = GainWidth + SUM_WIDTH;
  localparam int RW = GainWidth + DW;
  localparam int AW = ((RW > IW) ? RW : IW) + 2;

  logic                           advance;
  logic                           v1_q, v2_q, out_valid_q;
  logic signed [PW-1:0]           prod_p_q, prod_p_d;
  logic signed [IW-1:0]           prod_i_q, prod_i_d;
  logic signed [RW-1:0]           prod_d_q, prod_d_d;
  logic signed [AW-1:0]           acc_q, acc_d;
  logic signed [SAMPLE_WIDTH-1:0] drive_q, drive_d;
  logic signed [AW-1:0]           scaled, hi_ext, lo_ext, clip_hi;

  assign advance = !out_valid_q || !out_stall_i;
  assign pop_o   = advance && !q_stat_i.empty;

  always_comb begin
    prod_p_d = gain_prop_i * err_i;
    prod_i_d = gain_integ_i * integ_i;
    prod_d_d = gain_deriv_i * diff_i;
    acc_d    = AW'(prod_p_q) + AW'(prod_i_q) + AW'(prod_d_q);
    scaled   = acc_q >>> GAIN_FRAC_BITS;
    hi_ext   = AW'(limit_high_i);
    lo_ext   = AW'(limit_low_i);
    clip_hi  = (scaled > hi_ext) ? hi_ext : scaled;
    drive_d  = (clip_hi < lo_ext) ? limit_low_i : clip_hi[SAMPLE_WIDTH-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      v1_q        <= pop_o;
      v2_q        <= v1_q;
      out_valid_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      prod_p_q <= prod_p_d;
      prod_i_q <= prod_i_d;
      prod_d_q <= prod_d_d;
      acc_q    <= acc_d;
      drive_q  <= drive_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign drive_o     = drive_q;

endmodule

FILE: src/positional_pid_step_top.sv
// ----------------------------------------------------------------------------
// positional_pid_step_top
// Drive comes from a register after the queue, product and sum registers.
// One tick per cycle until the four-entry queue fills on output stalls.
// Cycle time is set by the gain multipliers and the wide three-term sum.
// Reset clears the error history and integral and loads default gains and
// limits (zero gains, full-scale limits); no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module positional_pid_step_top #(
  parameter int SAMPLE_WIDTH   = pid_pkg::DefSampleWidth,
  parameter int GAIN_FRAC_BITS = pid_pkg::DefGainFracBits,
  parameter int SUM_WIDTH      = pid_pkg::DefSumWidth,
  localparam int CfgWidth      = (SAMPLE_WIDTH > pid_pkg::GainWidth) ?
                                 SAMPLE_WIDTH : pid_pkg::GainWidth
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [pid_pkg::CfgIdxWidth-1:0]   cfg_idx_i,
  input  logic [CfgWidth-1:0]               cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [SAMPLE_WIDTH-1:0]    setpoint_i,
  input  logic signed [SAMPLE_WIDTH-1:0]    measured_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [SAMPLE_WIDTH-1:0]    drive_o
);
  import pid_pkg::*;

  localparam int EW = SAMPLE_WIDTH + 1;
  localparam int DW = SAMPLE_WIDTH + 2;
  localparam int QW = EW + DW + SUM_WIDTH;

  logic signed [GainWidth-1:0]    gain_prop_q, gain_integ_q, gain_deriv_q;
  logic signed [SAMPLE_WIDTH-1:0] limit_high_q, limit_low_q;

  logic                        push, pop;
  q_stat_t                     q_stat;
  logic signed [EW-1:0]        f_err, b_err;
  logic signed [DW-1:0]        f_diff, b_diff;
  logic signed [SUM_WIDTH-1:0] f_integ, b_integ;
  logic [QW-1:0]               q_wdata, q_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_prop_q  <= '0;
      gain_integ_q <= '0;
      gain_deriv_q <= '0;
      limit_high_q <= {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
      limit_low_q  <= {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_GAIN_PROP:  gain_prop_q  <= cfg_data_i[GainWidth-1:0];
        REG_GAIN_INTEG: gain_integ_q <= cfg_data_i[GainWidth-1:0];
        REG_GAIN_DERIV: gain_deriv_q <= cfg_data_i[GainWidth-1:0];
        REG_LIMIT_HIGH: limit_high_q <= cfg_data_i[SAMPLE_WIDTH-1:0];
        REG_LIMIT_LOW:  limit_low_q  <= cfg_data_i[SAMPLE_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  pid_front #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .SUM_WIDTH    (SUM_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .setpoint_i   (setpoint_i),
    .measured_i   (measured_i),
    .gain_integ_i (gain_integ_q),
    .q_stat_i     (q_stat),
    .push_o       (push),
    .err_o        (f_err),
    .diff_o       (f_diff),
    .integ_o      (f_integ)
  );

  assign q_wdata = {f_err, f_diff, f_integ};

  pid_queue #(
    .Width (QW),
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .wdata_i  (q_wdata),
    .pop_i    (pop),
    .rdata_o  (q_rdata),
    .q_stat_o (q_stat)
  );

  assign b_err   = q_rdata[QW-1 -: EW];
  assign b_diff  = q_rdata[SUM_WIDTH +: DW];
  assign b_integ = q_rdata[SUM_WIDTH-1:0];

  pid_back #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
    .SUM_WIDTH      (SUM_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_stat_i     (q_stat),
    .pop_o        (pop),
    .err_i        (b_err),
    .diff_i       (b_diff),
    .integ_i      (b_integ),
    .gain_prop_i  (gain_prop_q),
    .gain_integ_i (gain_integ_q),
    .gain_deriv_i (gain_deriv_q),
    .limit_high_i (limit_high_q),
    .limit_low_i  (limit_low_q),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .drive_o      (drive_o)
  );

endmodule

FILE: src/pid_checker.sv
// ----------------------------------------------------------------------------
// pid_checker
// Port-level checks for the positional PID step block, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pid_checker #(
  parameter int SAMPLE_WIDTH = pid_pkg::DefSampleWidth,
  localparam int CfgWidth    = (SAMPLE_WIDTH > pid_pkg::GainWidth) ?
                               SAMPLE_WIDTH : pid_pkg::GainWidth
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [pid_pkg::CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [CfgWidth-1:0]             cfg_data_i,
  input  logic                            in_valid_i,
  input  logic                            in_stall_o,
  input  logic                            out_valid_o,
  input  logic                            out_stall_i,
  input  logic signed [SAMPLE_WIDTH-1:0]  drive_o
);
  import pid_pkg::*;

  localparam int PendW = $clog2(QueueDepth + 5);

  logic signed [SAMPLE_WIDTH-1:0] hi_q, lo_q;
  logic [PendW-1:0]               pending_q;
  logic                           in_xact, out_xact;

  assign in_xact  = in_valid_i && !in_stall_o;
  assign out_xact = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hi_q <= {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
      lo_q <= {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    end else if (cfg_we_i) begin
      if (cfg_reg_e'(cfg_idx_i) == REG_LIMIT_HIGH) begin
        hi_q <= cfg_data_i[SAMPLE_WIDTH-1:0];
      end
      if (cfg_reg_e'(cfg_idx_i) == REG_LIMIT_LOW) begin
        lo_q <= cfg_data_i[SAMPLE_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (in_xact && !out_xact) begin
      pending_q <= pending_q + 1'b1;
    end else if (out_xact && !in_xact) begin
      pending_q <= pending_q - 1'b1;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(drive_o))
    else $error("stalled drive transaction dropped or changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled while no result is waiting");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_q != '0)
    else $error("drive transaction without an accepted tick");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (lo_q <= hi_q) |-> (drive_o <= hi_q) && (drive_o >= lo_q))
    else $error("drive outside configured limits");

endmodule

bind positional_pid_step_top pid_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_pid_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_we_i    (cfg_we_i),
  .cfg_idx_i   (cfg_idx_i),
  .cfg_data_i  (cfg_data_i),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .drive_o     (drive_o)
);

FILE: sim/positional_pid_step_top_test.sv
// ----------------------------------------------------------------------------
// positional_pid_step_top_test
// Self-checking testbench for the positional PID step block. A behavioral
// predictor tracks the error history, the saturating integral and the gain
// and limit registers, and produces the expected drive for every accepted
// tick. Directed ticks cover extremes, crossed limits, clearing the integral
// and unused register indexes. A short ramp winds the integral up and back
// down, and random ticks run under several register settings and idle/stall
// mixes, including a long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module positional_pid_step_top_test;

  import pid_pkg::*;

  localparam int SampleWidth = DefSampleWidth;
  localparam int FracBits    = DefGainFracBits;
  localparam int SumWidth    = DefSumWidth;
  localparam int CfgWidth    = (SampleWidth > GainWidth) ? SampleWidth : GainWidth;
  localparam int CycleLimit  = 1500000;
  localparam int SettleCycles = 8;

  localparam logic [CfgIdxWidth-1:0] RegUnusedLo = 3'd5;
  localparam logic [CfgIdxWidth-1:0] RegUnusedHi = 3'd7;

  localparam logic signed [SampleWidth-1:0] SampleMax = 16'sh7fff;
  localparam logic signed [SampleWidth-1:0] SampleMin = 16'sh8000;
  localparam longint SumMax = (longint'(1) <<< (SumWidth - 1)) - 1;
  localparam longint SumMin = -(longint'(1) <<< (SumWidth - 1));

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we_i = 1'b0;
  logic [CfgIdxWidth-1:0]        cfg_idx_i = '0;
  logic [CfgWidth-1:0]           cfg_data_i = '0;
  logic                          in_valid_i = 1'b0;
  logic                          in_stall_o;
  logic signed [SampleWidth-1:0] setpoint_i = '0;
  logic signed [SampleWidth-1:0] measured_i = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic signed [SampleWidth-1:0] drive_o;

  positional_pid_step_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .setpoint_i  (setpoint_i),
    .measured_i  (measured_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .drive_o     (drive_o)
  );

  always #5 clk_i = ~clk_i;

  // controller shadow state
  logic signed [GainWidth-1:0]   kp = '0;
  logic signed [GainWidth-1:0]   ki = '0;
  logic signed [GainWidth-1:0]   kd = '0;
  logic signed [SampleWidth-1:0] drive_max = SampleMax;
  logic signed [SampleWidth-1:0] drive_min = SampleMin;
  logic signed [SampleWidth:0]   prev_error = '0;
  logic signed [SumWidth-1:0]    error_integral = '0;

  logic signed [SampleWidth-1:0] expected_drive_q[$];
  logic signed [SampleWidth-1:0] want_drive;

  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  bit hold_req = 1'b0;
  int hold_cnt = 0;
  int fail_cnt = 0;
  int cycle_cnt = 0;

  function automatic logic signed [SampleWidth-1:0] next_drive(
      logic signed [SampleWidth-1:0] sp, logic signed [SampleWidth-1:0] ms);
    longint err;
    longint prev;
    longint acc;
    longint sum;
    longint res;
    err = longint'(sp) - longint'(ms);
    prev = longint'(prev_error);
    prev_error = err[SampleWidth:0];
    if (ki != 0) begin
      sum = longint'(error_integral) + err;
      if (sum > SumMax) sum = SumMax;
      if (sum < SumMin) sum = SumMin;
      error_integral = sum[SumWidth-1:0];
    end else begin
      error_integral = '0;
    end
    acc = longint'(kp) * err + longint'(ki) * longint'(error_integral)
        + longint'(kd) * (err - prev);
    res = acc >>> FracBits;
    if (res > longint'(drive_max)) res = longint'(drive_max);
    if (res < longint'(drive_min)) res = longint'(drive_min);
    return res[SampleWidth-1:0];
  endfunction

  // output stall, with a counted hold-off on request
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_cnt = 300;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall_i = 1'b1;
    end else begin
      out_stall_i = ($urandom_range(99) < sink_stall_pct);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_drive_q.size() == 0) begin
        fail_cnt++;
        $display("%0t unexpected transaction: drive %0d", $time, drive_o);
      end else begin
        want_drive = expected_drive_q.pop_front();
        if (drive_o !== want_drive) begin
          fail_cnt++;
          $display("%0t drive mismatch: expected %0d actual %0d", $time, want_drive,
                   drive_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_tick(input logic signed [SampleWidth-1:0] sp,
                           input logic signed [SampleWidth-1:0] ms);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    setpoint_i = sp;
    measured_i = ms;
    do @(posedge clk_i); while (in_stall_o);
    expected_drive_q.push_back(next_drive(sp, ms));
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_drive_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxWidth-1:0] idx,
                           input logic [CfgWidth-1:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    @(posedge clk_i);
    case (idx)
      REG_GAIN_PROP:  kp = val[GainWidth-1:0];
      REG_GAIN_INTEG: ki = val[GainWidth-1:0];
      REG_GAIN_DERIV: kd = val[GainWidth-1:0];
      REG_LIMIT_HIGH: drive_max = val[SampleWidth-1:0];
      REG_LIMIT_LOW:  drive_min = val[SampleWidth-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic write_gains(input logic [CfgWidth-1:0] p, input logic [CfgWidth-1:0] i,
                             input logic [CfgWidth-1:0] d);
    write_reg(REG_GAIN_PROP, p);
    write_reg(REG_GAIN_INTEG, i);
    write_reg(REG_GAIN_DERIV, d);
  endtask

  task automatic write_limits(input logic [CfgWidth-1:0] hi, input logic [CfgWidth-1:0] lo);
    write_reg(REG_LIMIT_HIGH, hi);
    write_reg(REG_LIMIT_LOW, lo);
  endtask

  function automatic logic [CfgWidth-1:0] pick_gain();
    int v;
    case ($urandom_range(4))
      0: v = $urandom_range(65535);
      1: v = $urandom_range(1024) - 512;
      2: v = $urandom_range(64) - 32;
      3: v = 0;
      default: v = $urandom_range(1) ? 32767 : -32768;
    endcase
    return v[CfgWidth-1:0];
  endfunction

  task automatic load_random_settings();
    int hi;
    int lo;
    write_gains(pick_gain(), pick_gain(), pick_gain());
    case ($urandom_range(3))
      0: begin
        hi = 32767;
        lo = -32768;
      end
      1: begin
        // crossed limits
        hi = $urandom_range(65535) - 32768;
        lo = hi + $urandom_range(1000);
        if (lo > 32767) lo = 32767;
      end
      default: begin
        lo = $urandom_range(65535) - 32768;
        hi = lo + $urandom_range(32767 - lo);
      end
    endcase
    write_limits(hi[CfgWidth-1:0], lo[CfgWidth-1:0]);
  endtask

  task automatic send_random(input int count);
    logic signed [SampleWidth-1:0] sp;
    logic signed [SampleWidth-1:0] ms;
    int delta;
    repeat (count) begin
      sp = SampleWidth'($urandom_range(65535));
      case ($urandom_range(7))
        0: begin
          sp = $urandom_range(1) ? SampleMax : SampleMin;
          ms = $urandom_range(1) ? SampleMax : SampleMin;
        end
        1, 2, 3, 4: begin
          // tracking near the setpoint
          delta = $urandom_range(512) - 256;
          ms = sp + delta[SampleWidth-1:0];
        end
        default: ms = SampleWidth'($urandom_range(65535));
      endcase
      send_tick(sp, ms);
    end
  endtask

  task automatic test_directed();
    // zero gains after reset
    send_tick(SampleMax, SampleMin);
    send_tick(SampleMin, SampleMax);
    settle();
    write_gains(16'sd256, 16'sd0, 16'sd0);
    send_tick(SampleMax, SampleMin);
    send_tick(SampleMin, SampleMax);
    send_tick(16'sd0, 16'sd0);
    send_tick(-16'sd1, 16'sd0);
    send_tick(16'sd100, -16'sd3);
    settle();
    write_gains(16'sh8000, 16'sh7fff, 16'sh7fff);
    send_tick(SampleMax, SampleMin);
    send_tick(SampleMin, SampleMax);
    send_tick(SampleMax, SampleMax);
    send_tick(16'sd5, 16'sd9);
    settle();
    // crossed limits
    write_limits(-16'sd100, 16'sd100);
    send_tick(SampleMax, SampleMin);
    send_tick(SampleMin, SampleMax);
    settle();
    // integral cleared while its gain is zero
    write_limits(SampleMax, SampleMin);
    write_gains(16'sd0, 16'sd256, 16'sd0);
    repeat (3) send_tick(16'sd10, 16'sd0);
    settle();
    write_reg(REG_GAIN_INTEG, 16'sd0);
    send_tick(16'sd10, 16'sd0);
    settle();
    write_reg(REG_GAIN_INTEG, 16'sd256);
    repeat (2) send_tick(16'sd10, 16'sd0);
    settle();
  endtask

  task automatic test_unused_index();
    write_reg(RegUnusedLo, 16'hffff);
    write_reg(RegUnusedHi, 16'h8000);
    send_tick(16'sd300, -16'sd300);
    send_tick(-16'sd7, 16'sd40);
    settle();
  endtask

  task automatic test_integral_ramp();
    write_gains(16'sd0, 16'sd1, 16'sd0);
    write_limits(SampleMax, SampleMin);
    repeat (20) send_tick(SampleMax, SampleMin);
    repeat (40) send_tick(SampleMin, SampleMax);
    repeat (10) send_tick(SampleMax, SampleMin);
    settle();
  endtask

  task automatic test_random_phases();
    int src_pct[4] = '{0, 55, 0, 35};
    int sink_pct[4] = '{0, 0, 55, 35};
    for (int ph = 0; ph < 4; ph++) begin
      src_idle_pct = src_pct[ph];
      sink_stall_pct = sink_pct[ph];
      repeat (2) begin
        load_random_settings();
        send_random(210);
        settle();
      end
    end
    src_idle_pct = 0;
    sink_stall_pct = 0;
  endtask

  task automatic test_output_hold_off();
    load_random_settings();
    @(negedge clk_i);
    hold_req = 1'b1;
    send_random(80);
    settle();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_unused_index();
    test_integral_ramp();
    test_random_phases();
    test_output_hold_off();

    // extreme gains and limits at the end
    write_gains(16'sh7fff, 16'sh8000, 16'sh8000);
    write_limits(SampleMax, SampleMin);
    send_random(40);
    settle();

    if (fail_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: positional_pid_step_top.f
src/pid_pkg.sv
src/pid_front.sv
src/pid_queue.sv
src/pid_back.sv
src/positional_pid_step_top.sv
src/pid_checker.sv
sim/positional_pid_step_top_test.sv
